[sv/spiram_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiram_pkg
// shared types and constants of the spi register access master
// ----------------------------------------------------------------------------
package spiram_pkg;

  localparam int unsigned MAX_DATA_BYTES = 4;

  localparam int unsigned IN_BITS   = 50;
  localparam int unsigned IN_BYTES  = 56;
  localparam int unsigned RES_BITS  = 37;
  localparam int unsigned OUT_BYTES = 40;

  // transaction phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SETUP = 2'd1;
  localparam logic [1:0] PH_XFER  = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  localparam logic [7:0] READ_FILL = 8'hff;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  tick_count;
    logic [2:0]  bit_index;
    logic [2:0]  byte_index;
    logic [2:0]  byte_total;
    logic [7:0]  shift_out;
    logic [31:0] shift_in;
    logic        req_mode;
    logic [2:0]  req_trans;
    logic [11:0] req_addr;
    logic [31:0] req_wdata;
    logic        clock_level;
  } state_t;

  // first member lands in the highest bits, so cs_n ends up in bit 0
  typedef struct packed {
    logic [31:0] rdata;
    logic        done_res;
    logic        busy_res;
    logic        mosi;
    logic        sck;
    logic        cs_n;
  } result_t;

  typedef struct packed {
    logic        miso;
    logic [31:0] wdata;
    logic [11:0] addr;
    logic [2:0]  trans;
    logic        mode;
    logic        start_req;
  } item_t;

endpackage

[sv/spiram_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiram_step
// next state and pin levels of the spi master for one tick
// ----------------------------------------------------------------------------
module spiram_step (
  input  spiram_pkg::state_t  st,
  input  spiram_pkg::item_t   item,
  input  logic [7:0]          half_period,
  output spiram_pkg::state_t  st_next,
  output spiram_pkg::result_t res
);
  import spiram_pkg::*;

  logic [7:0] h;
  logic [3:0] n_raw;
  logic [2:0] n_clamp;
  logic [2:0] byte_index_inc;
  logic       done;

  // data byte k of the latched request (the read fill byte in read mode), k two or more
  function automatic logic [7:0] data_byte(input state_t s, input logic [2:0] k);
    logic [2:0]  diff;
    logic [7:0]  b;
    diff = s.byte_total - 3'd1 - k;
    case (diff[1:0])
      2'd0:    b = s.req_wdata[7:0];
      2'd1:    b = s.req_wdata[15:8];
      2'd2:    b = s.req_wdata[23:16];
      default: b = s.req_wdata[31:24];
    endcase
    if (!s.req_mode) begin
      b = READ_FILL;
    end
    return b;
  endfunction

  assign h = (half_period == 8'd0) ? 8'd1 : half_period;
  assign n_raw = (item.trans == 3'd6) ? 4'd2 : {1'b0, item.trans} + 4'd1;
  assign n_clamp = (n_raw > 4'(MAX_DATA_BYTES)) ? 3'(MAX_DATA_BYTES) : n_raw[2:0];
  assign byte_index_inc = st.byte_index + 3'd1;

  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (item.start_req) begin
        st_next.req_mode    = item.mode;
        st_next.req_trans   = item.trans;
        st_next.req_addr    = item.addr;
        st_next.req_wdata   = item.wdata;
        st_next.byte_total  = n_clamp + 3'd2;
        st_next.byte_index  = 3'd0;
        st_next.bit_index   = 3'd7;
        st_next.clock_level = 1'b0;
        st_next.shift_in    = 32'd0;
        st_next.shift_out   = {item.mode, item.trans, item.addr[11:8]};
        st_next.phase       = PH_SETUP;
        st_next.tick_count  = 8'd1;
      end
    end else if (st.tick_count < h) begin
      st_next.tick_count = st.tick_count + 8'd1;
    end else begin
      st_next.tick_count = 8'd1;
      case (st.phase)
        PH_SETUP: begin
          st_next.phase       = PH_XFER;
          st_next.clock_level = 1'b0;
          st_next.bit_index   = 3'd7;
          st_next.byte_index  = 3'd0;
        end
        PH_XFER: begin
          if (!st.clock_level) begin
            st_next.clock_level = 1'b1;
            if (st.byte_index >= 3'd2 && !st.req_mode) begin
              st_next.shift_in = {st.shift_in[30:0], item.miso};
            end
          end else if (st.bit_index != 3'd0) begin
            st_next.bit_index   = st.bit_index - 3'd1;
            st_next.clock_level = 1'b0;
          end else begin
            st_next.byte_index  = byte_index_inc;
            st_next.clock_level = 1'b0;
            st_next.bit_index   = 3'd7;
            if (byte_index_inc >= st.byte_total) begin
              st_next.phase = PH_HOLD;
            end else if (byte_index_inc == 3'd1) begin
              st_next.shift_out = st.req_addr[7:0];
            end else begin
              st_next.shift_out = data_byte(st, byte_index_inc);
            end
          end
        end
        default: begin
          st_next.phase      = PH_IDLE;
          st_next.tick_count = 8'd0;
          done               = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.cs_n     = (st_next.phase == PH_IDLE);
    res.sck      = (st_next.phase == PH_XFER) && st_next.clock_level;
    res.mosi     = (st_next.phase == PH_XFER) && st_next.shift_out[st_next.bit_index];
    res.busy_res = (st_next.phase != PH_IDLE);
    res.done_res = done;
    res.rdata    = st_next.shift_in;
  end

endmodule

[sv/spiram_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiram_skid
// result register with a skid entry, registered ready toward the core
// ----------------------------------------------------------------------------
module spiram_skid #(
  parameter int unsigned WIDTH = 37
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             main_valid;
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             in_fire;
  logic             main_load;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign main_load = out_ready || !main_valid;
  assign out_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_load) begin
      main_valid <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

[sv/spi_register_access_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_register_access_master
// spi mode-0 register access master stepped by one input beat per tick
// ----------------------------------------------------------------------------
// each input beat is one time tick: a start request with the transaction
// (mode, trans, addr, wdata) and the miso level sampled at that tick. each
// beat yields exactly one output beat with the pin levels after the tick
// (cs_n, sck, mosi), busy, a one-tick done pulse and the read shift register.
// the cfg channel writes half_period_ticks, the length of every sck half
// period and of the cs setup and hold segments; it is always ready. the user
// must write it only while no beat is in flight (the block does not enforce
// this); a new value applies from the next tick on, even in the middle of a transaction.
// throughput: one beat per clock cycle, sustained while m_axis_tready is high,
// set by the single registered step (input register -> next-state logic ->
// result register). an input beat is held in the input register, stepped into
// the result buffer and shown on m_axis from there.
// reset: phase idle, divider back to 1, both the input register and the
// result buffer empty.
// when the receiver stalls, one result waits in the output register, one
// more in the skid entry and one tick in the input register; the input side
// then stops taking beats and the tick sequence pauses with no loss.
// ----------------------------------------------------------------------------
module spi_register_access_master (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // half_period_ticks
  // tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // start_req, mode, trans[2:0], addr[11:0],
                                      // wdata[31:0], miso, zero pad
  // pin levels per tick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // cs_n, sck, mosi, busy_res, done_res,
                                      // rdata[31:0], zero pad
);
  import spiram_pkg::*;

  // divider register
  logic [7:0] half_period;

  // input register
  logic  in_valid;
  item_t in_item;

  // transaction state
  state_t  st;
  state_t  st_next;
  result_t res;

  logic                res_ready;
  logic                advance;
  logic [RES_BITS-1:0] out_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= 8'd1;
    end else if (cfg_valid) begin
      half_period <= cfg_data;
    end
  end

  // the step fires when a tick is held and the result buffer has room
  assign advance       = in_valid && res_ready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_axis_tdata[IN_BITS-1:0];
    end
  end

  spiram_step u_step (
    .st          (st),
    .item        (in_item),
    .half_period (half_period),
    .st_next     (st_next),
    .res         (res)
  );

  // whole transaction state set to its reset values by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_IDLE;
      st.tick_count  <= 8'd0;
      st.bit_index   <= 3'd7;
      st.byte_index  <= 3'd0;
      st.byte_total  <= 3'd0;
      st.clock_level <= 1'b0;
      st.shift_in    <= 32'd0;
      st.shift_out   <= 8'd0;
      st.req_mode    <= 1'b0;
      st.req_trans   <= 3'd0;
      st.req_addr    <= 12'd0;
      st.req_wdata   <= 32'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  spiram_skid #(
    .WIDTH (RES_BITS)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (advance),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_bits)
  );

  assign m_axis_tdata = {(OUT_BYTES - RES_BITS)'(0), out_bits};

  // idle always has a cleared tick counter
  a_idle_tick : assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> st.tick_count == 8'd0)
    else $error("tick counter running while idle");

  // an active transaction carries header plus one to four data bytes
  a_total : assert property (@(posedge clk) disable iff (rst)
    st.phase != PH_IDLE |-> st.byte_total >= 3'd3 && st.byte_total <= 3'(MAX_DATA_BYTES + 2))
    else $error("byte total out of range");

  // the byte being shifted is always inside the transaction
  a_byte_index : assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_XFER |-> st.byte_index < st.byte_total)
    else $error("byte index past end of transaction");

  // a done pulse leaves the engine idle
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    advance && res.done_res |=> st.phase == PH_IDLE)
    else $error("done without return to idle");

endmodule
